// ===== hw/rtl/bracket_balance_checker_core_defines.svh =====
// Assertion macros for the bracket balance checker.
// Used by the top level; depends on nothing else.
`ifndef BRACKET_BALANCE_CHECKER_CORE_DEFINES_SVH
`define BRACKET_BALANCE_CHECKER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BBC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bracket checker assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define BBC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bracket checker assertion failed");

`endif

// ===== hw/rtl/bbc_pkg.sv =====
// Shared types and constants of the bracket balance checker.
// Used by bbc_front, bbc_back and the top level; depends on nothing.
package bbc_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int STACK_AW    = $clog2(STACK_DEPTH);
    localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CH_OPEN_ROUND   = 8'h28;
    localparam logic [7:0] CH_OPEN_CURLY   = 8'h7B;
    localparam logic [7:0] CH_OPEN_SQUARE  = 8'h5B;
    localparam logic [7:0] CH_CLOSE_ROUND  = 8'h29;
    localparam logic [7:0] CH_CLOSE_CURLY  = 8'h7D;
    localparam logic [7:0] CH_CLOSE_SQUARE = 8'h5D;

    typedef enum logic [2:0] {
        ERR_NONE        = 3'd0,
        ERR_CLOSE_EMPTY = 3'd1,
        ERR_MISMATCH    = 3'd2,
        ERR_UNCLOSED    = 3'd3,
        ERR_OVERFLOW    = 3'd4
    } err_t;

    typedef enum logic [1:0] {
        KIND_ROUND  = 2'd0,
        KIND_CURLY  = 2'd1,
        KIND_SQUARE = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        OP_IGNORE = 2'd0,
        OP_PUSH   = 2'd1,
        OP_POP    = 2'd2
    } op_code_t;

    // One classified character as it travels through the queue.
    typedef struct packed {
        op_code_t op;
        kind_t    kind;
        logic     last;
    } op_t;

endpackage

// ===== hw/rtl/bbc_front.sv =====
// Front part: accepts characters, classifies them and queues the operations.
// Depends on bbc_pkg.
module bbc_front (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         char_valid,
    output logic         char_stall,
    input  logic [7:0]   char_code,
    input  logic         end_of_string,
    output logic         q_valid,
    output bbc_pkg::op_t q_item,
    input  logic         q_pop
);
    import bbc_pkg::*;

    op_t                 entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CW-1:0] count_reg, count_next;
    op_t                 classified;
    logic                push;

    // Map the character to an operation and bracket kind.
    always_comb
    begin
        classified.last = end_of_string;
        unique case (char_code)
            CH_OPEN_ROUND:   begin classified.op = OP_PUSH;   classified.kind = KIND_ROUND;  end
            CH_OPEN_CURLY:   begin classified.op = OP_PUSH;   classified.kind = KIND_CURLY;  end
            CH_OPEN_SQUARE:  begin classified.op = OP_PUSH;   classified.kind = KIND_SQUARE; end
            CH_CLOSE_ROUND:  begin classified.op = OP_POP;    classified.kind = KIND_ROUND;  end
            CH_CLOSE_CURLY:  begin classified.op = OP_POP;    classified.kind = KIND_CURLY;  end
            CH_CLOSE_SQUARE: begin classified.op = OP_POP;    classified.kind = KIND_SQUARE; end
            default:         begin classified.op = OP_IGNORE; classified.kind = KIND_NONE;   end
        endcase
    end

    assign char_stall = (count_reg == QUEUE_CW'(QUEUE_DEPTH));
    assign push       = char_valid && !char_stall;
    assign q_valid    = (count_reg != '0);
    assign q_item     = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !q_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (q_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= classified;
        end
    end

endmodule

// ===== hw/rtl/bbc_back.sv =====
// Back part: runs the bracket stack and produces one registered result per item.
// Depends on bbc_pkg.
module bbc_back (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         q_valid,
    input  bbc_pkg::op_t q_item,
    output logic         q_pop,
    output logic         result_valid,
    input  logic         result_stall,
    output logic         verdict_ready,
    output logic         sequence_valid,
    output logic [2:0]   error_kind
);
    import bbc_pkg::*;

    kind_t                kind_mem [STACK_DEPTH];
    kind_t                top_reg;
    kind_t                below_reg;
    logic [DEPTH_W-1:0]   depth_reg, depth_next, depth_after;
    err_t                 err_reg, err_next, err_after;
    logic                 out_valid_reg, out_valid_next;
    logic                 verdict_reg, seq_ok_reg;
    err_t                 kind_out_reg;
    logic                 do_push, do_pop;
    logic [STACK_AW-1:0]  wr_addr, rd_addr;

    // The top of the stack and the entry under it live in registers, so a pop
    // compares at once and refills the entry under the top from the memory.
    assign q_pop   = q_valid && (!out_valid_reg || !result_stall);
    assign wr_addr = depth_reg[STACK_AW-1:0];
    assign rd_addr = depth_reg[STACK_AW-1:0] - STACK_AW'(3);

    always_comb
    begin
        do_push     = 1'b0;
        do_pop      = 1'b0;
        depth_after = depth_reg;
        err_after   = err_reg;
        if (err_reg == ERR_NONE)
        begin
            case (q_item.op)
                OP_PUSH:
                begin
                    if (depth_reg == DEPTH_W'(STACK_DEPTH))
                    begin
                        err_after = ERR_OVERFLOW;
                    end
                    else
                    begin
                        do_push     = q_pop;
                        depth_after = depth_reg + 1'b1;
                    end
                end
                OP_POP:
                begin
                    if (depth_reg == '0)
                    begin
                        err_after = ERR_CLOSE_EMPTY;
                    end
                    else
                    begin
                        do_pop      = q_pop;
                        depth_after = depth_reg - 1'b1;
                        if (top_reg != q_item.kind)
                        begin
                            err_after = ERR_MISMATCH;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (q_item.last && err_after == ERR_NONE && depth_after != '0)
        begin
            err_after = ERR_UNCLOSED;
        end
        depth_next = q_item.last ? '0 : depth_after;
        err_next   = q_item.last ? ERR_NONE : err_after;
    end

    always_comb
    begin
        if (q_pop)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && result_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg     <= '0;
            err_reg       <= ERR_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (q_pop)
            begin
                depth_reg <= depth_next;
                err_reg   <= err_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            kind_mem[wr_addr] <= q_item.kind;
            top_reg           <= q_item.kind;
            below_reg         <= top_reg;
        end
        else if (do_pop)
        begin
            top_reg   <= below_reg;
            below_reg <= kind_mem[rd_addr];
        end
        if (q_pop)
        begin
            verdict_reg  <= q_item.last;
            seq_ok_reg   <= q_item.last && (err_after == ERR_NONE);
            kind_out_reg <= q_item.last ? err_after : ERR_NONE;
        end
    end

    assign result_valid   = out_valid_reg;
    assign verdict_ready  = verdict_reg;
    assign sequence_valid = seq_ok_reg;
    assign error_kind     = kind_out_reg;

endmodule

// ===== hw/rtl/bracket_balance_checker_core.sv =====
// Top level of the bracket balance checker: front, queue and back joined.
// Depends on bbc_pkg, bbc_front, bbc_back and the assertion macro header.
//
//   channel   direction  handshake                    payload
//   char      in         char_valid / char_stall      char_code, end_of_string
//   result    out        result_valid / result_stall  verdict_ready, sequence_valid,
//                                                     error_kind
//
// One item is taken per cycle while char_stall is low; each item gives exactly one result
// item: the item is first written into the queue, and the back loads the result
// register from the queue head when it takes the item.
// The rate is set by the single stack update per cycle.
// Reset clears the stack depth, the sticky error, the queue and the result valid flag.
// A stalled result fills the queue; char_stall rises only once both entries are full.
`include "bracket_balance_checker_core_defines.svh"

module bracket_balance_checker_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       char_valid,
    output logic       char_stall,
    input  logic [7:0] char_code,
    input  logic       end_of_string,
    output logic       result_valid,
    input  logic       result_stall,
    output logic       verdict_ready,
    output logic       sequence_valid,
    output logic [2:0] error_kind
);
    import bbc_pkg::*;

    // Queue head handed from the front to the back.
    logic q_valid;
    op_t  q_item;
    logic q_pop;

    // The front classifies each character into push, pop or ignore and keeps
    // it in a short queue, so input and output stalls are decoupled.
    bbc_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .char_valid    (char_valid),
        .char_stall    (char_stall),
        .char_code     (char_code),
        .end_of_string (end_of_string),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop)
    );

    // The back holds the bracket stack and the sticky first error and
    // registers one result for every item it takes from the queue.
    bbc_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_item         (q_item),
        .q_pop          (q_pop),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .verdict_ready  (verdict_ready),
        .sequence_valid (sequence_valid),
        .error_kind     (error_kind)
    );

    // The back never takes from an empty queue.
    `BBC_ASSERT_SAME(a_pop_needs_item, clk, rst_n, q_pop, q_valid)
    // An accepted item is in the queue on the next cycle.
    `BBC_ASSERT_NEXT(a_accept_fills, clk, rst_n, char_valid && !char_stall, q_valid)
    // A balanced verdict carries no error code.
    `BBC_ASSERT_SAME(a_ok_no_error, clk, rst_n, result_valid && sequence_valid,
        verdict_ready && error_kind == ERR_NONE)
    // Results of characters that do not end a string are all zero.
    `BBC_ASSERT_SAME(a_mid_zero, clk, rst_n, result_valid && !verdict_ready,
        !sequence_valid && error_kind == ERR_NONE)

endmodule
